// ----- design/bjc_pkg.sv -----
// Shared constants, types and helpers for the binned joint correlation block.
package bjc_pkg;

    localparam int MAX_BINS_X = 64;
    localparam int MAX_BINS_Y = 64;

    localparam int IXW  = (MAX_BINS_X > 1) ? $clog2(MAX_BINS_X) : 1;
    localparam int KXW  = (MAX_BINS_Y > 1) ? $clog2(MAX_BINS_Y) : 1;
    localparam int IDW  = (IXW > KXW) ? IXW : KXW;
    localparam int GAW  = IXW + KXW;
    localparam int BNW  = 9;
    localparam int MW   = 32;
    localparam int SUMW = 48;
    localparam int OPW  = 82;
    localparam int BW   = 200;

    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] REG_BINS_X   = 3'd0;
    localparam logic [CFG_IW-1:0] REG_BINS_Y   = 3'd1;
    localparam logic [CFG_IW-1:0] REG_X_ORIGIN = 3'd2;
    localparam logic [CFG_IW-1:0] REG_X_STEP   = 3'd3;
    localparam logic [CFG_IW-1:0] REG_Y_ORIGIN = 3'd4;
    localparam logic [CFG_IW-1:0] REG_Y_STEP   = 3'd5;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_WEIGHT = 2'd1;
    localparam logic [1:0] STATUS_FLAT      = 2'd2;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_RMW   = 11'b00000000010,
        S_ROWS  = 11'b00000000100,
        S_COLS  = 11'b00000001000,
        S_GRID  = 11'b00000010000,
        S_DRAIN = 11'b00000100000,
        S_MLOAD = 11'b00001000000,
        S_MRUN  = 11'b00010000000,
        S_MPOST = 11'b00100000000,
        S_SRCH  = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } state_t;

    typedef enum logic [3:0] {
        OP_WSXX, OP_SXSX, OP_WSYY, OP_SYSY, OP_WSXY,
        OP_SXSY, OP_VXVY, OP_CVCV, OP_T2V
    } op_t;

    typedef enum logic [1:0] {
        ACC_NONE, ACC_ROW, ACC_COL, ACC_GRID
    } acc_t;

    function automatic logic [BNW-1:0] clamp_bins(input logic [6:0] v,
                                                  input logic [BNW-1:0] maxv);
        logic [BNW-1:0] e;
        e = BNW'(v);
        if (e == '0)
            return BNW'(1);
        return (e > maxv) ? maxv : e;
    endfunction

endpackage

// ----- design/binned_joint_correlation.sv -----
// Top level: weighted 2-D histogram correlation with memory-held grid and marginals.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata: weight
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata: corr, tuser: status
//  cfg       in   cfg_valid/cfg_ready            cfg_index, cfg_data
//
// Each weight is handled as a memory read of both marginals, then a write-back.
// After the last weight (total nonzero) a pass reads bx + by marginal entries and bx*by grid
// entries (one a cycle), then a bit-serial multiplier runs up to 8 products and a search of
// up to 16 steps on the magnitude.
// Reset clears control state and marginal valid bits; no clearing pass is needed.
// A waiting result holds m_axis; input is taken meanwhile until the next grid ends.
module binned_joint_correlation (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,   // [15:0] weight
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,   // [15:0] corr
    output logic [1:0]                    m_axis_tuser,   // [1:0] status
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bjc_pkg::CFG_IW-1:0]    cfg_index,
    input  logic [15:0]                   cfg_data
);
    import bjc_pkg::*;

    state_t state_reg, state_next;
    op_t    op_reg;
    acc_t   acc_reg;

    logic [6:0]  bins_x_reg, bins_y_reg;
    logic [15:0] x_origin_reg, x_step_reg, y_origin_reg, y_step_reg;

    logic [15:0] mem_grid [0:(1<<GAW)-1];
    logic [MW-1:0] mem_row [0:(1<<IXW)-1];
    logic [MW-1:0] mem_col [0:(1<<KXW)-1];
    logic [15:0]   grid_rd_reg;
    logic [MW-1:0] row_rd_reg, col_rd_reg;
    logic [MAX_BINS_X-1:0] row_vld_reg;
    logic [MAX_BINS_Y-1:0] col_vld_reg;

    logic [IXW-1:0] i_reg, sw_i_reg;
    logic [KXW-1:0] k_reg, sw_k_reg;
    logic [15:0]    w_reg;
    logic [MW-1:0]  total_reg;

    logic [IDW-1:0]     idx_d_reg;
    logic [2*IDW-1:0]   sq_d_reg;
    logic [GAW-1:0]     ik_d_reg;
    logic [SUMW-1:0]    sx_reg, sxx_reg, sy_reg, syy_reg, sxy_reg;

    logic [BW-1:0]  a_reg, p_reg, v_reg, c2_reg;
    logic [OPW-1:0] b_reg, t0_reg, vx_reg, vy_reg, cv_reg;
    logic           neg_reg;
    logic [15:0]    lo_reg, hi_reg, mid_reg;
    logic [31:0]    t2_reg;

    logic [15:0] res_corr_reg, out_corr_reg;
    logic [1:0]  res_status_reg, out_status_reg;
    logic        out_valid_reg;

    logic [BNW-1:0] bx_eff, by_eff;
    logic [IXW-1:0] last_i;
    logic [KXW-1:0] last_k;
    logic           in_acc, cfg_acc;
    logic [IXW-1:0] row_addr;
    logic [KXW-1:0] col_addr;
    logic [MW-1:0]  row_val, col_val;
    logic [IDW+MW-1:0]   p_lin_r, p_lin_c;
    logic [2*IDW+MW-1:0] p_sq_r, p_sq_c;
    logic [GAW+15:0]     p_xy;
    logic [BW-1:0]  op_a;
    logic [OPW-1:0] op_b, diff;
    logic [16:0]    mid_sum;
    logic [16:0]    t_wide;
    logic [15:0]    t_val;

    assign bx_eff = clamp_bins(bins_x_reg, BNW'(MAX_BINS_X));
    assign by_eff = clamp_bins(bins_y_reg, BNW'(MAX_BINS_Y));
    assign last_i = IXW'(bx_eff - BNW'(1));
    assign last_k = KXW'(by_eff - BNW'(1));

    assign cfg_ready     = (state_reg == S_IDLE);
    assign s_axis_tready = (state_reg == S_IDLE) && !cfg_valid;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cfg_acc       = cfg_valid && cfg_ready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_corr_reg;
    assign m_axis_tuser  = out_status_reg;

    assign row_addr = (state_reg == S_IDLE) ? i_reg : sw_i_reg;
    assign col_addr = (state_reg == S_IDLE) ? k_reg : sw_k_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc)
            mem_grid[{i_reg, k_reg}] <= s_axis_tdata;
        grid_rd_reg <= mem_grid[{sw_i_reg, sw_k_reg}];
        if (state_reg == S_RMW)
        begin
            mem_row[i_reg] <= row_val + MW'(w_reg);
            mem_col[k_reg] <= col_val + MW'(w_reg);
        end
        row_rd_reg <= mem_row[row_addr];
        col_rd_reg <= mem_col[col_addr];
    end

    always_comb
    begin
        if (state_reg == S_RMW)
        begin
            row_val = row_vld_reg[i_reg] ? row_rd_reg : '0;
            col_val = col_vld_reg[k_reg] ? col_rd_reg : '0;
        end
        else
        begin
            row_val = row_vld_reg[idx_d_reg[IXW-1:0]] ? row_rd_reg : '0;
            col_val = col_vld_reg[idx_d_reg[KXW-1:0]] ? col_rd_reg : '0;
        end
    end

    assign p_lin_r = idx_d_reg * row_val;
    assign p_sq_r  = sq_d_reg * row_val;
    assign p_lin_c = idx_d_reg * col_val;
    assign p_sq_c  = sq_d_reg * col_val;
    assign p_xy    = ik_d_reg * grid_rd_reg;

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (op_reg)
            OP_WSXX: begin op_a = BW'(total_reg); op_b = OPW'(sxx_reg); end
            OP_SXSX: begin op_a = BW'(sx_reg);    op_b = OPW'(sx_reg);  end
            OP_WSYY: begin op_a = BW'(total_reg); op_b = OPW'(syy_reg); end
            OP_SYSY: begin op_a = BW'(sy_reg);    op_b = OPW'(sy_reg);  end
            OP_WSXY: begin op_a = BW'(total_reg); op_b = OPW'(sxy_reg); end
            OP_SXSY: begin op_a = BW'(sx_reg);    op_b = OPW'(sy_reg);  end
            OP_VXVY: begin op_a = BW'(vx_reg);    op_b = vy_reg;        end
            OP_CVCV: begin op_a = BW'(cv_reg);    op_b = cv_reg;        end
            OP_T2V:  begin op_a = v_reg;          op_b = OPW'(t2_reg);  end
            default: begin op_a = '0;             op_b = '0;            end
        endcase
    end

    assign diff    = t0_reg - p_reg[OPW-1:0];
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} + 17'd1;
    assign t_wide  = {mid_sum[16:1], 1'b0} - 17'd1;
    assign t_val   = t_wide[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_WSXX;
            acc_reg        <= ACC_NONE;
            bins_x_reg     <= 7'd64;
            bins_y_reg     <= 7'd64;
            x_origin_reg   <= '0;
            x_step_reg     <= 16'd256;
            y_origin_reg   <= '0;
            y_step_reg     <= 16'd256;
            row_vld_reg    <= '0;
            col_vld_reg    <= '0;
            i_reg          <= '0;
            k_reg          <= '0;
            sw_i_reg       <= '0;
            sw_k_reg       <= '0;
            total_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && m_axis_tready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;

            case (acc_reg)
                ACC_ROW:
                begin
                    sx_reg  <= sx_reg + SUMW'(p_lin_r);
                    sxx_reg <= sxx_reg + SUMW'(p_sq_r);
                end
                ACC_COL:
                begin
                    sy_reg  <= sy_reg + SUMW'(p_lin_c);
                    syy_reg <= syy_reg + SUMW'(p_sq_c);
                end
                ACC_GRID: sxy_reg <= sxy_reg + SUMW'(p_xy);
                default: ;
            endcase
            if (!(state_reg inside {S_ROWS, S_COLS, S_GRID}))
                acc_reg <= ACC_NONE;

            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_acc)
                    begin
                        case (cfg_index)
                            REG_BINS_X:   bins_x_reg   <= cfg_data[6:0];
                            REG_BINS_Y:   bins_y_reg   <= cfg_data[6:0];
                            REG_X_ORIGIN: x_origin_reg <= cfg_data;
                            REG_X_STEP:   x_step_reg   <= cfg_data;
                            REG_Y_ORIGIN: y_origin_reg <= cfg_data;
                            REG_Y_STEP:   y_step_reg   <= cfg_data;
                            default: ;
                        endcase
                        if (cfg_index == REG_BINS_X || cfg_index == REG_BINS_Y ||
                            cfg_index == REG_X_ORIGIN || cfg_index == REG_X_STEP ||
                            cfg_index == REG_Y_ORIGIN || cfg_index == REG_Y_STEP)
                        begin
                            row_vld_reg <= '0;
                            col_vld_reg <= '0;
                            total_reg   <= '0;
                            i_reg       <= '0;
                            k_reg       <= '0;
                        end
                    end
                    if (in_acc)
                        w_reg <= s_axis_tdata;
                end
                S_RMW:
                begin
                    row_vld_reg[i_reg] <= 1'b1;
                    col_vld_reg[k_reg] <= 1'b1;
                    total_reg <= total_reg + MW'(w_reg);
                    if (k_reg == last_k)
                    begin
                        k_reg <= '0;
                        i_reg <= (i_reg == last_i) ? '0 : i_reg + IXW'(1);
                    end
                    else
                        k_reg <= k_reg + KXW'(1);
                    if (i_reg == last_i && k_reg == last_k)
                    begin
                        sw_i_reg <= '0;
                        sw_k_reg <= '0;
                        sx_reg   <= '0;
                        sxx_reg  <= '0;
                        sy_reg   <= '0;
                        syy_reg  <= '0;
                        sxy_reg  <= '0;
                        res_corr_reg   <= '0;
                        res_status_reg <= STATUS_NO_WEIGHT;
                    end
                end
                S_ROWS:
                begin
                    acc_reg   <= ACC_ROW;
                    idx_d_reg <= IDW'(sw_i_reg);
                    sq_d_reg  <= (2*IDW)'(sw_i_reg) * (2*IDW)'(sw_i_reg);
                    sw_i_reg  <= (sw_i_reg == last_i) ? '0 : sw_i_reg + IXW'(1);
                end
                S_COLS:
                begin
                    acc_reg   <= ACC_COL;
                    idx_d_reg <= IDW'(sw_k_reg);
                    sq_d_reg  <= (2*IDW)'(sw_k_reg) * (2*IDW)'(sw_k_reg);
                    sw_k_reg  <= (sw_k_reg == last_k) ? '0 : sw_k_reg + KXW'(1);
                end
                S_GRID:
                begin
                    acc_reg  <= ACC_GRID;
                    ik_d_reg <= GAW'(sw_i_reg) * GAW'(sw_k_reg);
                    if (sw_k_reg == last_k)
                    begin
                        sw_k_reg <= '0;
                        sw_i_reg <= (sw_i_reg == last_i) ? '0 : sw_i_reg + IXW'(1);
                    end
                    else
                        sw_k_reg <= sw_k_reg + KXW'(1);
                end
                S_DRAIN:
                    op_reg <= OP_WSXX;
                S_MLOAD:
                begin
                    a_reg <= op_a;
                    b_reg <= op_b;
                    p_reg <= '0;
                end
                S_MRUN:
                begin
                    if (b_reg != '0)
                    begin
                        if (b_reg[0])
                            p_reg <= p_reg + a_reg;
                        a_reg <= {a_reg[BW-2:0], 1'b0};
                        b_reg <= {1'b0, b_reg[OPW-1:1]};
                    end
                end
                S_MPOST:
                begin
                    case (op_reg)
                        OP_WSXX: begin t0_reg <= p_reg[OPW-1:0]; op_reg <= OP_SXSX; end
                        OP_SXSX: begin vx_reg <= diff;           op_reg <= OP_WSYY; end
                        OP_WSYY: begin t0_reg <= p_reg[OPW-1:0]; op_reg <= OP_SYSY; end
                        OP_SYSY:
                        begin
                            vy_reg <= diff;
                            op_reg <= OP_WSXY;
                            res_corr_reg   <= '0;
                            res_status_reg <= STATUS_FLAT;
                        end
                        OP_WSXY: begin t0_reg <= p_reg[OPW-1:0]; op_reg <= OP_SXSY; end
                        OP_SXSY:
                        begin
                            neg_reg <= (t0_reg < p_reg[OPW-1:0]);
                            cv_reg  <= (t0_reg < p_reg[OPW-1:0]) ?
                                       (p_reg[OPW-1:0] - t0_reg) : diff;
                            op_reg  <= OP_VXVY;
                        end
                        OP_VXVY: begin v_reg <= p_reg; op_reg <= OP_CVCV; end
                        OP_CVCV:
                        begin
                            c2_reg <= {p_reg[BW-33:0], 32'd0};
                            lo_reg <= '0;
                            hi_reg <= 16'd32768;
                        end
                        OP_T2V:
                        begin
                            if (p_reg <= c2_reg)
                                lo_reg <= mid_reg;
                            else
                                hi_reg <= mid_reg - 16'd1;
                        end
                        default: ;
                    endcase
                end
                S_SRCH:
                begin
                    if (lo_reg < hi_reg)
                    begin
                        mid_reg <= mid_sum[16:1];
                        t2_reg  <= t_val * t_val;
                        op_reg  <= OP_T2V;
                    end
                    else
                    begin
                        res_status_reg <= STATUS_OK;
                        if (neg_reg)
                            res_corr_reg <= 16'(17'h10000 - {1'b0, lo_reg});
                        else
                            res_corr_reg <= (lo_reg > 16'd32767) ? 16'd32767 : lo_reg;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_corr_reg   <= res_corr_reg;
                        out_status_reg <= res_status_reg;
                        row_vld_reg    <= '0;
                        col_vld_reg    <= '0;
                        total_reg      <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_acc)
                    state_next = S_RMW;
            S_RMW:
                if (i_reg == last_i && k_reg == last_k)
                    state_next = ((total_reg + MW'(w_reg)) == '0) ? S_DONE : S_ROWS;
                else
                    state_next = S_IDLE;
            S_ROWS:
                if (sw_i_reg == last_i)
                    state_next = S_COLS;
            S_COLS:
                if (sw_k_reg == last_k)
                    state_next = S_GRID;
            S_GRID:
                if (sw_i_reg == last_i && sw_k_reg == last_k)
                    state_next = S_DRAIN;
            S_DRAIN:
                state_next = S_MLOAD;
            S_MLOAD:
                state_next = S_MRUN;
            S_MRUN:
                if (b_reg == '0)
                    state_next = S_MPOST;
            S_MPOST:
                case (op_reg)
                    OP_SYSY:
                        if (x_step_reg == '0 || y_step_reg == '0 ||
                            vx_reg == '0 || diff == '0)
                            state_next = S_DONE;
                        else
                            state_next = S_MLOAD;
                    OP_CVCV, OP_T2V:
                        state_next = S_SRCH;
                    default:
                        state_next = S_MLOAD;
                endcase
            S_SRCH:
                state_next = (lo_reg < hi_reg) ? S_MLOAD : S_DONE;
            S_DONE:
                if (!out_valid_reg || m_axis_tready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule
